// ===== rtl/core/bbrq_pkg.sv =====
// bbrq_pkg: shared types, codes, widths and reset values of the record queue
// no dependencies; imported by bbrq_front, bbrq_back and the top module
package bbrq_pkg;

  localparam int QUEUE_DEPTH_DEF  = 256;
  localparam int BATCH_MAX_DEF    = 64;
  localparam int HANDLE_WIDTH_DEF = 16;

  localparam int REQ_W       = 2;
  localparam int BYTES_W     = 20;
  localparam int QLR_W       = 9;
  localparam int TOTAL_W     = 24;
  localparam int BLR_W       = 7;
  localparam int CNT_OUT_W   = 32;
  localparam int KIND_W      = 2;
  localparam int REG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_FILL_W = $clog2(CMDQ_DEPTH + 1);

  localparam logic [QLR_W-1:0]   QLR_RESET = 9'd256;
  localparam logic [TOTAL_W-1:0] QLB_RESET = 24'd1048576;
  localparam logic [BLR_W-1:0]   BLR_RESET = 7'd64;
  localparam logic [TOTAL_W-1:0] BLB_RESET = 24'd65536;

  localparam logic [REG_IDX_W-1:0] REG_QUEUE_LIMIT_RECORDS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_QUEUE_LIMIT_BYTES   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BATCH_LIMIT_RECORDS = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_BATCH_LIMIT_BYTES   = 2'd3;

  localparam logic [REQ_W-1:0] REQ_ENQUEUE    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TAKE_BATCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DROP_ALL   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLOSE      = 2'd3;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_TAKE  = 2'd1,
    OP_DROP  = 2'd2,
    OP_CLOSE = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ   = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef struct packed {
    op_t                op;
    logic [BYTES_W-1:0] bytes;
  } cmd_t;

  function automatic logic [CNT_OUT_W-1:0] sat32(input logic [CNT_OUT_W:0] s);
    return s[CNT_OUT_W] ? '1 : s[CNT_OUT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/bbrq_ram.sv =====
// bbrq_ram: generic single-write, single-read memory with registered read data
// no dependencies
module bbrq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bbrq_front.sv =====
// bbrq_front: takes command items, decodes the request and holds them in a short queue
// depends on bbrq_pkg
module bbrq_front import bbrq_pkg::*; #(
  parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [REQ_W-1:0]        in_req_type,
  input  logic [HANDLE_WIDTH-1:0] in_record_handle,
  input  logic [BYTES_W-1:0]      in_record_bytes,
  output logic                    cmd_valid,
  output cmd_t                    cmd,
  output logic [HANDLE_WIDTH-1:0] cmd_handle,
  input  logic                    cmd_pop
);

  cmd_t                    cmdq_r [CMDQ_DEPTH];
  logic [HANDLE_WIDTH-1:0] hndq_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]      wr_ptr_r;
  logic [CMDQ_AW-1:0]      rd_ptr_r;
  logic [CMDQ_FILL_W-1:0]  fill_r;
  logic                    push;
  op_t                     op_dec;

  always_comb begin
    unique case (in_req_type)
      REQ_ENQUEUE:    op_dec = OP_ENQ;
      REQ_TAKE_BATCH: op_dec = OP_TAKE;
      REQ_DROP_ALL:   op_dec = OP_DROP;
      REQ_CLOSE:      op_dec = OP_CLOSE;
      default:        op_dec = OP_ENQ;
    endcase
  end

  assign busy      = (fill_r == CMDQ_FILL_W'(CMDQ_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (fill_r != '0);
  assign cmd       = cmdq_r[rd_ptr_r];
  assign cmd_handle = hndq_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !cmd_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (!push && cmd_pop) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmdq_r[wr_ptr_r] <= '{op: op_dec, bytes: in_record_bytes};
      hndq_r[wr_ptr_r] <= in_record_handle;
    end
  end

endmodule

// ===== rtl/core/bbrq_back.sv =====
// bbrq_back: queue state, limits, record stores and the batch scan/emit sequencer
// depends on bbrq_pkg and bbrq_ram
module bbrq_back import bbrq_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int BATCH_MAX    = BATCH_MAX_DEF,
  parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [REG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    cmd_valid,
  input  cmd_t                    cmd,
  input  logic [HANDLE_WIDTH-1:0] cmd_handle,
  output logic                    cmd_pop,
  output logic                    out_valid,
  output logic [KIND_W-1:0]       out_kind,
  output logic                    out_accepted,
  output logic                    out_flush_hint,
  output logic [HANDLE_WIDTH-1:0] out_entry_handle,
  output logic [BYTES_W-1:0]      out_entry_bytes,
  output logic                    out_last,
  output logic [QLR_W-1:0]        out_queue_depth,
  output logic [TOTAL_W-1:0]      out_queue_total_bytes,
  output logic [CNT_OUT_W-1:0]    out_dropped_total
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int LIM_W = (CNT_W > QLR_W) ? CNT_W : QLR_W;
  localparam int BW    = $clog2(BATCH_MAX + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } st_t;

  st_t state_r, state_nxt;

  logic [QLR_W-1:0]   qlr_r;
  logic [TOTAL_W-1:0] qlb_r;
  logic [BLR_W-1:0]   blr_r;
  logic [TOTAL_W-1:0] blb_r;

  logic [PTR_W-1:0]     head_r, tail_r;
  logic [CNT_W-1:0]     count_r;
  logic [TOTAL_W-1:0]   bt_r;
  logic                 closed_r;
  logic [CNT_OUT_W-1:0] dropped_r;

  logic [PTR_W-1:0]   scan_ptr_r, take_ptr_r, emit_ptr_r;
  logic [BW-1:0]      n_r, cap_r, emit_left_r;
  logic [TOTAL_W-1:0] used_r, scan_bt_r;
  logic               sv_r;
  logic               pend_valid_r, pend_last_r;

  logic                    out_valid_r;
  kind_t                   out_kind_r;
  logic                    out_accepted_r, out_flush_hint_r, out_last_r;
  logic [HANDLE_WIDTH-1:0] out_handle_r;
  logic [BYTES_W-1:0]      out_bytes_r;
  logic [QLR_W-1:0]        out_depth_r;
  logic [TOTAL_W-1:0]      out_total_r;
  logic [CNT_OUT_W-1:0]    out_dropped_r;

  logic [LIM_W-1:0]        lim_ext;
  logic [TOTAL_W:0]        enq_sum;
  logic                    enq_drop, enq_hint;
  logic [CNT_W-1:0]        count_inc;
  logic [BW-1:0]           cap_c;
  logic                    take_go;
  logic [CNT_OUT_W-1:0]    drop_one, drop_all;
  logic [BYTES_W-1:0]      size_q;
  logic [HANDLE_WIDTH-1:0] handle_q;
  logic [PTR_W-1:0]        rd_addr;
  logic                    ram_we;
  logic                    scan_stop;
  logic [TOTAL_W:0]        used_sum;
  logic [TOTAL_W-1:0]      used_next, scan_bt_dec;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign lim_ext   = (LIM_W'(qlr_r) > LIM_W'(QUEUE_DEPTH)) ? LIM_W'(QUEUE_DEPTH)
                                                           : LIM_W'(qlr_r);
  assign enq_sum   = {1'b0, bt_r} + (TOTAL_W + 1)'(cmd.bytes);
  assign count_inc = count_r + 1'b1;
  assign enq_drop  = closed_r || (LIM_W'(count_r) >= lim_ext) || (enq_sum > {1'b0, qlb_r});
  assign enq_hint  = (LIM_W'(count_inc) >= LIM_W'(blr_r)) || (enq_sum[TOTAL_W-1:0] >= blb_r);
  assign cap_c     = (blr_r > BLR_W'(BATCH_MAX)) ? BW'(BATCH_MAX) : BW'(blr_r);
  assign take_go   = (cap_c != '0) && (count_r != '0);
  assign drop_one  = sat32({1'b0, dropped_r} + (CNT_OUT_W + 1)'(1));
  assign drop_all  = sat32({1'b0, dropped_r} + (CNT_OUT_W + 1)'(count_r));

  assign cmd_pop = (state_r == ST_IDLE) && cmd_valid && !pend_valid_r;
  assign ram_we  = cmd_pop && (cmd.op == OP_ENQ) && !enq_drop;
  assign rd_addr = (state_r == ST_EMIT) ? emit_ptr_r : scan_ptr_r;

  assign scan_stop = (n_r == cap_r) || (LIM_W'(n_r) == LIM_W'(count_r)) ||
                     ((n_r != '0) && (TOTAL_W'(size_q) > (blb_r - used_r)));
  assign used_sum    = {1'b0, used_r} + (TOTAL_W + 1)'(size_q);
  assign used_next   = (used_sum > {1'b0, blb_r}) ? blb_r : used_sum[TOTAL_W-1:0];
  assign scan_bt_dec = (scan_bt_r < TOTAL_W'(size_q)) ? '0 : scan_bt_r - TOTAL_W'(size_q);

  bbrq_ram #(.WIDTH(HANDLE_WIDTH), .DEPTH(QUEUE_DEPTH)) u_handle_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (cmd_handle),
    .raddr (rd_addr),
    .rdata (handle_q)
  );

  bbrq_ram #(.WIDTH(BYTES_W), .DEPTH(QUEUE_DEPTH)) u_size_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (cmd.bytes),
    .raddr (rd_addr),
    .rdata (size_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (cmd_pop && (cmd.op == OP_TAKE) && take_go) state_nxt = ST_SCAN;
      ST_SCAN: if (sv_r && scan_stop) state_nxt = ST_EMIT;
      ST_EMIT: if (emit_left_r == BW'(1)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      qlr_r        <= QLR_RESET;
      qlb_r        <= QLB_RESET;
      blr_r        <= BLR_RESET;
      blb_r        <= BLB_RESET;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      bt_r         <= '0;
      closed_r     <= 1'b0;
      dropped_r    <= '0;
      scan_ptr_r   <= '0;
      take_ptr_r   <= '0;
      emit_ptr_r   <= '0;
      n_r          <= '0;
      cap_r        <= '0;
      emit_left_r  <= '0;
      used_r       <= '0;
      scan_bt_r    <= '0;
      sv_r         <= 1'b0;
      pend_valid_r <= 1'b0;
      pend_last_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= pend_valid_r;
      pend_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_QUEUE_LIMIT_RECORDS: qlr_r <= cfg_data[QLR_W-1:0];
          REG_QUEUE_LIMIT_BYTES:   qlb_r <= cfg_data[TOTAL_W-1:0];
          REG_BATCH_LIMIT_RECORDS: blr_r <= cfg_data[BLR_W-1:0];
          REG_BATCH_LIMIT_BYTES:   blb_r <= cfg_data[TOTAL_W-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_pop) begin
            unique case (cmd.op) inside
              OP_ENQ: begin
                out_valid_r <= 1'b1;
                if (enq_drop) begin
                  dropped_r <= drop_one;
                end else begin
                  tail_r  <= ptr_next(tail_r);
                  count_r <= count_inc;
                  bt_r    <= enq_sum[TOTAL_W-1:0];
                end
              end
              OP_TAKE: begin
                if (!take_go) begin
                  out_valid_r <= 1'b1;
                end else begin
                  scan_ptr_r <= head_r;
                  take_ptr_r <= head_r;
                  n_r        <= '0;
                  cap_r      <= cap_c;
                  used_r     <= '0;
                  scan_bt_r  <= bt_r;
                  sv_r       <= 1'b0;
                end
              end
              OP_DROP, OP_CLOSE: begin
                out_valid_r <= 1'b1;
                dropped_r   <= drop_all;
                count_r     <= '0;
                bt_r        <= '0;
                head_r      <= '0;
                tail_r      <= '0;
                if (cmd.op == OP_CLOSE) begin
                  closed_r <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          scan_ptr_r <= ptr_next(scan_ptr_r);
          sv_r       <= 1'b1;
          if (sv_r) begin
            if (scan_stop) begin
              head_r      <= take_ptr_r;
              count_r     <= count_r - CNT_W'(n_r);
              bt_r        <= scan_bt_r;
              emit_ptr_r  <= head_r;
              emit_left_r <= n_r;
            end else begin
              n_r        <= n_r + 1'b1;
              used_r     <= used_next;
              scan_bt_r  <= scan_bt_dec;
              take_ptr_r <= ptr_next(take_ptr_r);
            end
          end
        end
        ST_EMIT: begin
          emit_ptr_r   <= ptr_next(emit_ptr_r);
          emit_left_r  <= emit_left_r - 1'b1;
          pend_valid_r <= 1'b1;
          pend_last_r  <= (emit_left_r == BW'(1));
        end
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pend_valid_r) begin
      out_kind_r       <= KIND_ENTRY;
      out_accepted_r   <= 1'b0;
      out_flush_hint_r <= 1'b0;
      out_handle_r     <= handle_q;
      out_bytes_r      <= size_q;
      out_last_r       <= pend_last_r;
      out_depth_r      <= QLR_W'(count_r);
      out_total_r      <= bt_r;
      out_dropped_r    <= dropped_r;
    end else if (cmd_pop) begin
      out_handle_r <= '0;
      out_bytes_r  <= '0;
      out_last_r   <= 1'b1;
      case (cmd.op) inside
        OP_ENQ: begin
          out_kind_r       <= KIND_ENQ;
          out_accepted_r   <= !enq_drop;
          out_flush_hint_r <= !enq_drop && enq_hint;
          out_depth_r      <= QLR_W'(enq_drop ? count_r : count_inc);
          out_total_r      <= enq_drop ? bt_r : enq_sum[TOTAL_W-1:0];
          out_dropped_r    <= enq_drop ? drop_one : dropped_r;
        end
        OP_TAKE: begin
          out_kind_r       <= KIND_EMPTY;
          out_accepted_r   <= 1'b0;
          out_flush_hint_r <= 1'b0;
          out_depth_r      <= QLR_W'(count_r);
          out_total_r      <= bt_r;
          out_dropped_r    <= dropped_r;
        end
        OP_DROP, OP_CLOSE: begin
          out_kind_r       <= KIND_DONE;
          out_accepted_r   <= 1'b0;
          out_flush_hint_r <= 1'b0;
          out_depth_r      <= '0;
          out_total_r      <= '0;
          out_dropped_r    <= drop_all;
        end
        default: ;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_kind              = out_kind_r;
  assign out_accepted          = out_accepted_r;
  assign out_flush_hint        = out_flush_hint_r;
  assign out_entry_handle      = out_handle_r;
  assign out_entry_bytes       = out_bytes_r;
  assign out_last              = out_last_r;
  assign out_queue_depth       = out_depth_r;
  assign out_queue_total_bytes = out_total_r;
  assign out_dropped_total     = out_dropped_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LIM_W'(count_r) <= LIM_W'(QUEUE_DEPTH))
    else $error("record count above queue depth");

  a_empty_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (bt_r == '0))
    else $error("empty queue holds bytes");

  a_scan_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (n_r <= cap_r))
    else $error("batch scan past its cap");

  a_no_pop_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> !cmd_pop)
    else $error("command taken while a batch entry is in flight");

  a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && sv_r && scan_stop) |=> (emit_left_r != '0))
    else $error("batch emit with no entries");
`endif

endmodule

// ===== rtl/core/bounded_batching_record_queue_top.sv =====
// bounded_batching_record_queue_top: count and byte bounded batching record queue
// depends on bbrq_pkg, bbrq_front, bbrq_back (and bbrq_ram below it)
//
// usage:
//   command item: start with in_req_type, in_record_handle, in_record_bytes, taken
//   when start is high and busy is low. busy rises only when the two-entry command
//   queue is full.
//   results: one cycle each on the out_ ports, marked by out_valid; out_last marks
//   the final result of an item. results cannot be held off.
//   limits: cfg_we, cfg_index, cfg_data write a limit register; the user writes only
//   while the block is idle, the block itself does not enforce it.
// timing:
//   enqueue, drop-all and close: the item passes the command queue and its result is
//   registered when the back end pops it; one item per cycle while no batch take is in flight.
//   take batch of n entries: a scan pass over the size store decides n, one read per
//   cycle, then a second pass emits one entry per cycle.
// reset: queue empty and open, counters zero, limits at their defaults; the record
//   stores are not cleared and need no clearing pass.
module bounded_batching_record_queue_top import bbrq_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int BATCH_MAX    = BATCH_MAX_DEF,
  parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [REQ_W-1:0]        in_req_type,
  input  logic [HANDLE_WIDTH-1:0] in_record_handle,
  input  logic [BYTES_W-1:0]      in_record_bytes,
  output logic                    out_valid,
  output logic [KIND_W-1:0]       out_kind,
  output logic                    out_accepted,
  output logic                    out_flush_hint,
  output logic [HANDLE_WIDTH-1:0] out_entry_handle,
  output logic [BYTES_W-1:0]      out_entry_bytes,
  output logic                    out_last,
  output logic [QLR_W-1:0]        out_queue_depth,
  output logic [TOTAL_W-1:0]      out_queue_total_bytes,
  output logic [CNT_OUT_W-1:0]    out_dropped_total,
  input  logic                    cfg_we,
  input  logic [REG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic                    cmd_valid;
  cmd_t                    cmd;
  logic [HANDLE_WIDTH-1:0] cmd_handle;
  logic                    cmd_pop;

  bbrq_front #(.HANDLE_WIDTH(HANDLE_WIDTH)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_record_handle (in_record_handle),
    .in_record_bytes  (in_record_bytes),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_handle       (cmd_handle),
    .cmd_pop          (cmd_pop)
  );

  bbrq_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .BATCH_MAX    (BATCH_MAX),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .cmd_valid             (cmd_valid),
    .cmd                   (cmd),
    .cmd_handle            (cmd_handle),
    .cmd_pop               (cmd_pop),
    .out_valid             (out_valid),
    .out_kind              (out_kind),
    .out_accepted          (out_accepted),
    .out_flush_hint        (out_flush_hint),
    .out_entry_handle      (out_entry_handle),
    .out_entry_bytes       (out_entry_bytes),
    .out_last              (out_last),
    .out_queue_depth       (out_queue_depth),
    .out_queue_total_bytes (out_queue_total_bytes),
    .out_dropped_total     (out_dropped_total)
  );

endmodule
